@@ rtl/receive_ring_line_assembler_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef RECEIVE_RING_LINE_ASSEMBLER_MACROS_SVH
`define RECEIVE_RING_LINE_ASSEMBLER_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define RRLA_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rrla assertion failed");

// Check a condition in the cycle after its trigger.
`define RRLA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rrla assertion failed");

`endif

@@ rtl/rrla_pkg.sv @@
package rrla_pkg;

    localparam int BYTE_W         = 8;
    localparam int CAP_W          = 7;
    localparam int LEN_W          = 6;
    localparam int CAP_MAX        = 64;
    localparam int RING_DEPTH_DEF = 128;
    localparam int S_TDATA_W      = 8;
    localparam int S_TUSER_W      = 1;
    localparam int M_TDATA_W      = 16;
    localparam int M_TUSER_W      = 2;

    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

    localparam logic MODE_PUSH = 1'b0;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(CAP_MAX);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EMIT_RD,
        ST_EMIT_CHK,
        ST_RESULT
    } state_t;

    // Bytes kept per line: capacity minus one, capacity clamped to 1..CAP_MAX.
    function automatic logic [LEN_W-1:0] keep_limit(input logic [CAP_W-1:0] cap);
        logic [LEN_W-1:0] lim;
        if (cap == '0) begin
            lim = '0;
        end else if (cap > CAP_W'(CAP_MAX)) begin
            lim = LEN_W'(CAP_MAX - 1);
        end else begin
            lim = LEN_W'(cap - CAP_W'(1));
        end
        return lim;
    endfunction

endpackage

@@ rtl/receive_ring_line_assembler.sv @@
// Channel   Dir  Handshake           Payload
// s_        in   s_tvalid/s_tready   s_tuser: mode; s_tdata: rx_byte
// m_        out  m_tvalid/m_tready   m_tuser: found, byte_valid; m_tdata: byte, length; m_tlast
// cfg_      in   cfg_valid/cfg_ready cfg_data: line_capacity
//
// Pushes are taken on consecutive cycles while idle; s_tready is low while a request runs.
// After it is accepted, a request walks the ring from the read pointer, reading then checking
// each byte, up to the newline; with no newline it walks to the write pointer, then loads the
// lone result. A found line is read and checked byte by byte up to its last kept byte,
// or gives a lone result when nothing is kept. A stalled m_ side holds emitting and the result.
// Synchronous reset (aresetn) clears pointers and output valid, sets capacity 64; ring kept.
module receive_ring_line_assembler #(
    parameter int RING_DEPTH = rrla_pkg::RING_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rrla_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] rx_byte
    input  logic [rrla_pkg::S_TUSER_W-1:0] s_tuser,   // [0] mode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rrla_pkg::M_TDATA_W-1:0] m_tdata,   // [7:0] line_byte, [13:8] line_length
    output logic [rrla_pkg::M_TUSER_W-1:0] m_tuser,   // [0] line_found, [1] byte_valid
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rrla_pkg::CAP_W-1:0]     cfg_data
);
    import rrla_pkg::*;

`include "receive_ring_line_assembler_macros.svh"

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  walk_ptr_reg, walk_ptr_next;
    logic [PTR_W-1:0]  lf_ptr_reg, lf_ptr_next;
    logic [LEN_W-1:0]  total_reg, total_next;
    logic [LEN_W-1:0]  emit_cnt_reg, emit_cnt_next;
    logic              found_reg, found_next;
    logic [CAP_W-1:0]  cap_reg;

    logic              out_valid_reg, out_valid_next;
    logic              out_found_reg, out_found_next;
    logic              out_bvalid_reg, out_bvalid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;
    logic              out_last_reg, out_last_next;

    logic              in_fire;
    logic              out_free;
    logic              mem_we;
    logic              mem_re;
    logic [PTR_W-1:0]  wr_ptr_inc;
    logic [LEN_W-1:0]  keep_max;
    logic              is_lf;
    logic              is_cr;
    logic              emit_last;

    assign s_tready   = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign in_fire    = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;
    assign wr_ptr_inc = ptr_inc(wr_ptr_reg);
    assign keep_max   = keep_limit(cap_reg);
    assign is_lf      = (rd_data_reg == CH_LF);
    assign is_cr      = (rd_data_reg == CH_CR);
    assign emit_last  = (emit_cnt_reg + LEN_W'(1) == total_reg);

    // Store a pushed byte unless the ring is full.
    assign mem_we = in_fire && (s_tuser[0] == MODE_PUSH) && (wr_ptr_inc != rd_ptr_reg);
    // Read only in request states, so a write never meets a read of the same entry.
    assign mem_re = (state_reg == ST_SCAN_RD && walk_ptr_reg != wr_ptr_reg) ||
                    (state_reg == ST_EMIT_RD);

    // Ring memory with registered read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[wr_ptr_reg] <= s_tdata[BYTE_W-1:0];
        end
        if (mem_re) begin
            rd_data_reg <= ring_mem[walk_ptr_reg];
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire && s_tuser[0] != MODE_PUSH) begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                state_next = (walk_ptr_reg == wr_ptr_reg) ? ST_RESULT : ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (!is_lf) begin
                    state_next = ST_SCAN_RD;
                end else if (total_reg == '0) begin
                    state_next = ST_RESULT;
                end else begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_CHK;
            end
            ST_EMIT_CHK: begin
                if (is_cr) begin
                    state_next = ST_EMIT_RD;
                end else if (out_free) begin
                    state_next = emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and output register updates.
    always_comb begin
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        walk_ptr_next   = walk_ptr_reg;
        lf_ptr_next     = lf_ptr_reg;
        total_next      = total_reg;
        emit_cnt_next   = emit_cnt_reg;
        found_next      = found_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_found_next  = out_found_reg;
        out_bvalid_next = out_bvalid_reg;
        out_byte_next   = out_byte_reg;
        out_len_next    = out_len_reg;
        out_last_next   = out_last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (mem_we) begin
                    wr_ptr_next = wr_ptr_inc;
                end
                // Start a request walk at the read pointer.
                walk_ptr_next = rd_ptr_reg;
                total_next    = '0;
                found_next    = 1'b0;
            end
            ST_SCAN_RD: begin
            end
            ST_SCAN_CHK: begin
                if (is_lf) begin
                    found_next    = 1'b1;
                    lf_ptr_next   = walk_ptr_reg;
                    walk_ptr_next = rd_ptr_reg;
                    emit_cnt_next = '0;
                end else begin
                    // Count keepable bytes, saturating at the keep limit (capacity minus one).
                    if (!is_cr && total_reg < keep_max) begin
                        total_next = total_reg + LEN_W'(1);
                    end
                    walk_ptr_next = ptr_inc(walk_ptr_reg);
                end
            end
            ST_EMIT_RD: begin
            end
            ST_EMIT_CHK: begin
                if (is_cr) begin
                    walk_ptr_next = ptr_inc(walk_ptr_reg);
                end else if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_found_next  = 1'b1;
                    out_bvalid_next = 1'b1;
                    out_byte_next   = rd_data_reg;
                    out_len_next    = emit_last ? total_reg : '0;
                    out_last_next   = emit_last;
                    emit_cnt_next   = emit_cnt_reg + LEN_W'(1);
                    walk_ptr_next   = ptr_inc(walk_ptr_reg);
                    if (emit_last) begin
                        rd_ptr_next = ptr_inc(lf_ptr_reg);
                    end
                end
            end
            ST_RESULT: begin
                // Lone result: no line, or a line with nothing kept.
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_found_next  = found_reg;
                    out_bvalid_next = 1'b0;
                    out_byte_next   = '0;
                    out_len_next    = '0;
                    out_last_next   = 1'b1;
                    if (found_reg) begin
                        rd_ptr_next = ptr_inc(lf_ptr_reg);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        walk_ptr_reg   <= walk_ptr_next;
        lf_ptr_reg     <= lf_ptr_next;
        total_reg      <= total_next;
        emit_cnt_reg   <= emit_cnt_next;
        found_reg      <= found_next;
        out_found_reg  <= out_found_next;
        out_bvalid_reg <= out_bvalid_next;
        out_byte_reg   <= out_byte_next;
        out_len_reg    <= out_len_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - BYTE_W - LEN_W){1'b0}}, out_len_reg, out_byte_reg};
    assign m_tuser  = {out_bvalid_reg, out_found_reg};
    assign m_tlast  = out_last_reg;

    // Pointers stay inside the ring.
    `RRLA_ASSERT_NOW(a_ptr_range, aclk, aresetn, 1'b1,
        (wr_ptr_reg <= PTR_LAST) && (rd_ptr_reg <= PTR_LAST))
    // The emit walk ends on a kept byte before ever reaching the newline.
    `RRLA_ASSERT_NOW(a_emit_before_lf, aclk, aresetn,
        (state_reg == ST_EMIT_RD) || (state_reg == ST_EMIT_CHK),
        (walk_ptr_reg != lf_ptr_reg) && (emit_cnt_reg < total_reg))
    // The read pointer moves only when the final result of a line is loaded.
    `RRLA_ASSERT_NEXT(a_rd_ptr_hold, aclk, aresetn,
        (state_reg == ST_IDLE) || (state_reg == ST_SCAN_RD) || (state_reg == ST_SCAN_CHK),
        rd_ptr_reg == $past(rd_ptr_reg))
    // Nothing is written to the ring during a request walk.
    `RRLA_ASSERT_NOW(a_no_write_walk, aclk, aresetn, state_reg != ST_IDLE, !mem_we)

endmodule
